// ===== design/fchc_pkg.sv =====
package fchc_pkg;

   // data set geometry
   localparam int NUM_VALUES = 1024;
   localparam int MAX_ITEMS  = 65535;

   // field widths
   localparam int VALUE_W    = 10;
   localparam int SET_SIZE_W = 11;
   localparam int COUNT_W    = 16;

   // derived widths
   localparam int IDX_W      = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
   localparam int ADDR_CNT_W = IDX_W + 1;
   localparam int TAKEN_W    = $clog2(NUM_VALUES + 1);

   // result saturation limit
   localparam int SET_SIZE_MAX = (1 << SET_SIZE_W) - 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_TAKE,
      ST_FINISH
   } state_type;

endpackage

// ===== design/frequency_cover_half_count_top.sv =====
// Greedy half-cover counter. A data set streams in one value per req transfer, with
// req_last on the final one. Each value bumps its count in a NUM_VALUES-entry histogram
// RAM and the running item total. Once the set closes, the counts are taken from largest
// to smallest until the removed total reaches total - floor(total/2), and one rsp
// transfer reports how many distinct values that took (saturated to 2047) together with
// the overflow flag, which tells that items beyond MAX_ITEMS were dropped. Values at or
// above NUM_VALUES are dropped silently. Each item is a histogram read, then a write-back
// through the RAM's read and write ports. The closing item then runs a search with one
// shared compare unit: one scan pass over the NUM_VALUES entries for each distinct count
// level that is needed, a take step per value taken plus a step that closes each level,
// then a finish step (held while the rsp register is still full) and a clearing pass
// over the NUM_VALUES entries that zeroes the histogram for the next set. After reset
// the same clearing pass runs before the first item is taken. A result waiting in the
// rsp register does not hold up loading of the next set; only when that next set has
// also finished does it wait, with req stalled, for the rsp register to free up.
module frequency_cover_half_count_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fchc_pkg::VALUE_W-1:0]    req_value,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fchc_pkg::SET_SIZE_W-1:0] rsp_set_size,
   output logic                            rsp_overflow
);

   import fchc_pkg::*;

   // sequencer state
   state_type state_ff, state_in;

   // shared address counter: scan read address and clear write address
   logic [ADDR_CNT_W-1:0] addr_cnt_ff, addr_cnt_in;

   // item being written back
   logic [IDX_W-1:0] item_addr_ff, item_addr_in;
   logic             item_count_ff, item_count_in;
   logic             item_last_ff, item_last_in;

   // set totals
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               overflow_seen_ff, overflow_seen_in;

   // search state
   logic               rd_valid_ff, rd_valid_in;
   logic [COUNT_W-1:0] best_ff, best_in;
   logic [TAKEN_W-1:0] match_ff, match_in;
   logic [COUNT_W-1:0] thresh_ff, thresh_in;
   logic               use_thresh_ff, use_thresh_in;
   logic [COUNT_W-1:0] removed_ff, removed_in;
   logic [TAKEN_W-1:0] taken_ff, taken_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SET_SIZE_W-1:0] rsp_set_size_ff, rsp_set_size_in;
   logic                  rsp_overflow_ff, rsp_overflow_in;

   // histogram ram
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [COUNT_W-1:0] ram_wdata;
   logic               ram_re;
   logic [IDX_W-1:0]   ram_raddr;
   logic [COUNT_W-1:0] ram_rdata;

   // decoded conditions
   logic               req_xfer;
   logic               rsp_xfer;
   logic               rsp_free;
   logic               scan_issue;
   logic               scan_done;
   logic               clear_done;
   logic               candidate;
   logic [COUNT_W-1:0] need;
   logic               need_met;

   fchc_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(NUM_VALUES)
   ) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // scan reads run while the address counter is below the depth
   assign scan_issue = (addr_cnt_ff < ADDR_CNT_W'(NUM_VALUES));
   assign scan_done  = !scan_issue && !rd_valid_ff;
   assign clear_done = (addr_cnt_ff == ADDR_CNT_W'(NUM_VALUES - 1));

   // removal target: total minus floor of half
   assign need     = total_ff - (total_ff >> 1);
   assign need_met = (removed_ff >= need);

   // shared compare: nonzero and below the previous level
   assign candidate = (ram_rdata != '0) && (!use_thresh_ff || (ram_rdata < thresh_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = item_last_ff ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = (best_ff == '0) ? ST_FINISH : ST_TAKE;
            end
         end
         ST_TAKE: begin
            if (need_met) begin
               state_in = ST_FINISH;
            end else if (match_ff == '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall        = 1'b1;
      ram_we           = 1'b0;
      ram_waddr        = addr_cnt_ff[IDX_W-1:0];
      ram_wdata        = '0;
      ram_re           = 1'b0;
      ram_raddr        = addr_cnt_ff[IDX_W-1:0];
      addr_cnt_in      = addr_cnt_ff;
      item_addr_in     = item_addr_ff;
      item_count_in    = item_count_ff;
      item_last_in     = item_last_ff;
      total_in         = total_ff;
      overflow_seen_in = overflow_seen_ff;
      rd_valid_in      = 1'b0;
      best_in          = best_ff;
      match_in         = match_ff;
      thresh_in        = thresh_ff;
      use_thresh_in    = use_thresh_ff;
      removed_in       = removed_ff;
      taken_in         = taken_ff;
      rsp_valid_in     = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_set_size_in  = rsp_set_size_ff;
      rsp_overflow_in  = rsp_overflow_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_wdata   = '0;
            addr_cnt_in = clear_done ? '0 : addr_cnt_ff + ADDR_CNT_W'(1);
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            ram_raddr = IDX_W'(req_value);
            if (req_xfer) begin
               ram_re       = 1'b1;
               item_addr_in = IDX_W'(req_value);
               item_last_in = req_last;
               // out-of-range values are dropped without flagging
               item_count_in = 1'b0;
               if (32'(req_value) < NUM_VALUES) begin
                  if (32'(total_ff) < MAX_ITEMS) begin
                     item_count_in = 1'b1;
                  end else begin
                     overflow_seen_in = 1'b1;
                  end
               end
            end
         end
         ST_UPDATE: begin
            ram_we    = item_count_ff;
            ram_waddr = item_addr_ff;
            ram_wdata = ram_rdata + COUNT_W'(1);
            if (item_count_ff) begin
               total_in = total_ff + COUNT_W'(1);
            end
            // arm the first search pass
            addr_cnt_in   = '0;
            best_in       = '0;
            match_in      = '0;
            use_thresh_in = 1'b0;
            removed_in    = '0;
            taken_in      = '0;
         end
         ST_SCAN: begin
            if (scan_issue) begin
               ram_re      = 1'b1;
               rd_valid_in = 1'b1;
               addr_cnt_in = addr_cnt_ff + ADDR_CNT_W'(1);
            end
            if (rd_valid_ff && candidate) begin
               if (ram_rdata > best_ff) begin
                  best_in  = ram_rdata;
                  match_in = TAKEN_W'(1);
               end else if (ram_rdata == best_ff) begin
                  match_in = match_ff + TAKEN_W'(1);
               end
            end
         end
         ST_TAKE: begin
            if (!need_met) begin
               if (match_ff == '0) begin
                  // level used up: search the next lower level
                  thresh_in     = best_ff;
                  use_thresh_in = 1'b1;
                  best_in       = '0;
                  addr_cnt_in   = '0;
               end else begin
                  removed_in = removed_ff + best_ff;
                  taken_in   = taken_ff + TAKEN_W'(1);
                  match_in   = match_ff - TAKEN_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_set_size_in = (32'(taken_ff) > SET_SIZE_MAX) ?
                                 SET_SIZE_W'(SET_SIZE_MAX) : SET_SIZE_W'(taken_ff);
               rsp_overflow_in  = overflow_seen_ff;
               total_in         = '0;
               overflow_seen_in = 1'b0;
               addr_cnt_in      = '0;
            end
         end
         default: begin
            addr_cnt_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         addr_cnt_ff      <= '0;
         total_ff         <= '0;
         overflow_seen_ff <= 1'b0;
         rd_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         addr_cnt_ff      <= addr_cnt_in;
         total_ff         <= total_in;
         overflow_seen_ff <= overflow_seen_in;
         rd_valid_ff      <= rd_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_addr_ff    <= item_addr_in;
      item_count_ff   <= item_count_in;
      item_last_ff    <= item_last_in;
      best_ff         <= best_in;
      match_ff        <= match_in;
      thresh_ff       <= thresh_in;
      use_thresh_ff   <= use_thresh_in;
      removed_ff      <= removed_in;
      taken_ff        <= taken_in;
      rsp_set_size_ff <= rsp_set_size_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_set_size = rsp_set_size_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // a new result only comes out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared outside the finish step");

   // the removed sum never runs past the item total
   a_removed_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAKE) |-> (removed_ff <= total_ff))
      else $error("removed count exceeds item total");

   // a later search level stays strictly below the one before
   a_level_descends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAKE && use_thresh_ff) |-> (best_ff < thresh_ff))
      else $error("search level did not descend");

   // item total is frozen while the cover search runs
   a_total_frozen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_TAKE) |=> $stable(total_ff))
      else $error("item total changed during search");

endmodule

// ===== design/fchc_ram.sv =====
module fchc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic                                 re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
